/* sv/tlfp_pkg.sv */
// Package: constants, types and helpers of the telemetry line field parser.
package tlfp_pkg;

    localparam int LINE_CAP = 128;
    localparam int LEN_W    = $clog2(LINE_CAP);
    localparam int NUM_KEYS = 5;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] HDR_TEXT    = "DMS,";
    localparam logic [63:0] KEY_PERCLOS = "PERCLOS:";
    localparam logic [39:0] KEY_YAWN    = "YAWN:";
    localparam logic [47:0] KEY_PHONE   = "PHONE:";
    localparam logic [31:0] KEY_HAT     = "HAT:";
    localparam logic [31:0] KEY_LVL     = "LVL:";

    localparam logic [LEN_W-1:0] HDR_LAST_POS = LEN_W'(3);
    localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(5);
    localparam logic [LEN_W-1:0] LEN_MAX      = LEN_W'(LINE_CAP - 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd40;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_PRE  = 3'd1;
    localparam logic [2:0] PH_INT  = 3'd2;
    localparam logic [2:0] PH_FRAC = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    typedef struct packed {
        logic        data_valid;
        logic [15:0] perclos;
        logic [15:0] yawn_cnt;
        logic [15:0] phone_val;
        logic [15:0] hat_on;
        logic [15:0] fatigue_level;
        logic        line_accepted;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

/* sv/tlfp_ifs.sv */
// Interfaces: input request, result and configuration channels.
interface tlfp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;
    modport source (output valid, kind, rx_byte, input ready);
    modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface tlfp_out_if;
    logic               valid;
    logic               ready;
    logic               data_valid;
    logic        [15:0] perclos;
    logic signed [15:0] yawn_cnt;
    logic signed [15:0] phone_val;
    logic signed [15:0] hat_on;
    logic signed [15:0] fatigue_level;
    logic               line_accepted;
    modport source (output valid, data_valid, perclos, yawn_cnt, phone_val, hat_on,
                    fatigue_level, line_accepted, input ready);
    modport sink   (input valid, data_valid, perclos, yawn_cnt, phone_val, hat_on,
                    fatigue_level, line_accepted, output ready);
endinterface

interface tlfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] timeout_ticks;
    modport source (output valid, timeout_ticks, input ready);
    modport sink   (input valid, timeout_ticks, output ready);
endinterface

/* sv/telemetry_line_field_parser_unit.sv */
// Top level: telemetry line field parser with result register and skid stage.
//  channel   dir  payload
//  i_in      in   kind, rx_byte
//  o_out     out  data_valid, perclos, yawn_cnt, phone_val, hat_on,
//                 fatigue_level, line_accepted
//  i_cfg     in   timeout_ticks
// One request per cycle while the skid stage is empty; the result is registered on acceptance.
// Key search and number parsing advance one character per request.
// Reset clears the line, fields, valid flag and timeout (to 40).
// A stalled result is held; one more request fits in the skid stage.
module telemetry_line_field_parser_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    tlfp_in_if.sink    i_in,
    tlfp_out_if.source o_out,
    tlfp_cfg_if.sink   i_cfg
);
    import tlfp_pkg::*;

    logic [15:0]      r_timeout;
    logic [LEN_W-1:0] r_len, n_len;
    logic [55:0]      r_recent, n_recent;
    logic             r_hdr_ok, n_hdr_ok;
    logic [2:0]       r_ph [NUM_KEYS], n_ph [NUM_KEYS];
    logic             r_neg [NUM_KEYS], n_neg [NUM_KEYS];
    logic [15:0]      r_mag [1:NUM_KEYS-1], n_mag [1:NUM_KEYS-1];
    logic [3:0]       r_whole, n_whole;
    logic [13:0]      r_frac, n_frac;
    logic [2:0]       r_fd, n_fd;
    logic [15:0]      r_field [NUM_KEYS], n_field [NUM_KEYS];
    logic             r_vflag, n_vflag;
    logic [15:0]      r_idle, n_idle;
    t_result          r_out, r_sk, new_res;
    logic             r_out_v, r_sk_v;

    logic       acc, take, accepted, stored;
    logic [7:0] c;
    logic [63:0] win;
    logic [NUM_KEYS-1:0] hit;
    logic [18:0] mag_nx [1:NUM_KEYS-1];
    logic [6:0]  whole_nx;
    logic [16:0] sfrac, total;

    assign acc   = i_in.valid & i_in.ready;
    assign take  = r_out_v & o_out.ready;
    assign c     = i_in.rx_byte;
    assign win   = {r_recent, c};
    assign i_in.ready  = ~r_sk_v;
    assign i_cfg.ready = 1'b1;

    assign hit[0] = (win == KEY_PERCLOS);
    assign hit[1] = (win[39:0] == KEY_YAWN);
    assign hit[2] = (win[47:0] == KEY_PHONE);
    assign hit[3] = (win[31:0] == KEY_HAT);
    assign hit[4] = (win[31:0] == KEY_LVL);

    always_comb begin
        unique case (r_fd)
            3'd0:    sfrac = 17'd0;
            3'd1:    sfrac = 17'(r_frac) * 17'd1000;
            3'd2:    sfrac = 17'(r_frac) * 17'd100;
            3'd3:    sfrac = 17'(r_frac) * 17'd10;
            default: sfrac = 17'(r_frac);
        endcase
        total = 17'(r_whole) * 17'd10000 + sfrac;
    end

    always_comb begin
        n_len    = r_len;
        n_recent = r_recent;
        n_hdr_ok = r_hdr_ok;
        n_whole  = r_whole;
        n_frac   = r_frac;
        n_fd     = r_fd;
        n_vflag  = r_vflag;
        n_idle   = r_idle;
        accepted = 1'b0;
        stored   = 1'b0;
        whole_nx = 7'(r_whole) * 7'd10 + 7'(c - CH_ZERO);
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_ph[k]    = r_ph[k];
            n_neg[k]   = r_neg[k];
            n_field[k] = r_field[k];
        end
        for (int k = 1; k < NUM_KEYS; k++) begin
            n_mag[k]  = r_mag[k];
            mag_nx[k] = 19'(r_mag[k]) * 19'd10 + 19'(c - CH_ZERO);
        end
        if (i_in.kind == 1'b0) begin
            if (c == CH_LF || c == CH_CR) begin
                if (r_len > MIN_LEN && r_hdr_ok) begin
                    accepted = 1'b1;
                    n_vflag  = 1'b1;
                    n_idle   = 16'd0;
                    if (r_ph[0] != PH_IDLE) begin
                        n_field[0] = r_neg[0] ? 16'd0 :
                                     (total > 17'd65535 ? 16'hFFFF : total[15:0]);
                    end
                    for (int k = 1; k < NUM_KEYS; k++) begin
                        if (r_ph[k] != PH_IDLE) begin
                            if (r_neg[k]) begin
                                n_field[k] = (r_mag[k] > 16'd32768) ? 16'h8000
                                                                     : 16'd0 - r_mag[k];
                            end else begin
                                n_field[k] = (r_mag[k] > 16'd32767) ? 16'h7FFF : r_mag[k];
                            end
                        end
                    end
                end
                n_len    = '0;
                n_recent = '0;
                n_hdr_ok = 1'b0;
                for (int k = 0; k < NUM_KEYS; k++) n_ph[k] = PH_IDLE;
            end else if (r_len < LEN_MAX) begin
                stored   = 1'b1;
                n_len    = r_len + 1'b1;
                n_recent = win[55:0];
                if (r_len == HDR_LAST_POS) n_hdr_ok = (win[31:0] == HDR_TEXT);
            end
        end else if (r_vflag) begin
            if (r_idle >= r_timeout) n_vflag = 1'b0;
            else n_idle = r_idle + 16'd1;
        end

        if (stored) begin
            priority case (r_ph[0])
                PH_IDLE: begin
                    if (hit[0]) begin
                        n_ph[0] = PH_PRE;
                        n_neg[0] = 1'b0;
                        n_whole = '0;
                        n_frac = '0;
                        n_fd = '0;
                    end
                end
                PH_PRE, PH_INT: begin
                    if (r_ph[0] == PH_PRE && is_blank(c)) begin
                        n_ph[0] = PH_PRE;
                    end else if (r_ph[0] == PH_PRE && (c == CH_PLUS || c == CH_MINUS)) begin
                        n_neg[0] = (c == CH_MINUS);
                        n_ph[0]  = PH_INT;
                    end else if (is_digit(c)) begin
                        n_whole = (whole_nx > 7'd10) ? 4'd10 : whole_nx[3:0];
                        n_ph[0] = PH_INT;
                    end else if (c == CH_DOT) begin
                        n_ph[0] = PH_FRAC;
                    end else begin
                        n_ph[0] = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (is_digit(c)) begin
                        if (r_fd < 3'd4) begin
                            n_frac = 14'(r_frac * 14'd10 + 14'(c - CH_ZERO));
                            n_fd   = r_fd + 3'd1;
                        end
                    end else begin
                        n_ph[0] = PH_DONE;
                    end
                end
                default: n_ph[0] = r_ph[0];
            endcase
            for (int k = 1; k < NUM_KEYS; k++) begin
                priority case (r_ph[k])
                    PH_IDLE: begin
                        if (hit[k]) begin
                            n_ph[k]  = PH_PRE;
                            n_neg[k] = 1'b0;
                            n_mag[k] = '0;
                        end
                    end
                    PH_PRE, PH_INT: begin
                        if (r_ph[k] == PH_PRE && is_blank(c)) begin
                            n_ph[k] = PH_PRE;
                        end else if (r_ph[k] == PH_PRE &&
                                     (c == CH_PLUS || c == CH_MINUS)) begin
                            n_neg[k] = (c == CH_MINUS);
                            n_ph[k]  = PH_INT;
                        end else if (is_digit(c)) begin
                            n_mag[k] = (mag_nx[k] > 19'd40000) ? 16'd40000 : mag_nx[k][15:0];
                            n_ph[k]  = PH_INT;
                        end else begin
                            n_ph[k] = PH_DONE;
                        end
                    end
                    default: n_ph[k] = r_ph[k];
                endcase
            end
        end

        new_res.data_valid    = n_vflag;
        new_res.perclos       = n_field[0];
        new_res.yawn_cnt      = n_field[1];
        new_res.phone_val     = n_field[2];
        new_res.hat_on        = n_field[3];
        new_res.fatigue_level = n_field[4];
        new_res.line_accepted = accepted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_len     <= '0;
            r_recent  <= '0;
            r_hdr_ok  <= 1'b0;
            r_vflag   <= 1'b0;
            r_idle    <= '0;
            r_out_v   <= 1'b0;
            r_sk_v    <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_ph[k]    <= PH_IDLE;
                r_field[k] <= '0;
            end
        end else begin
            if (i_cfg.valid) r_timeout <= i_cfg.timeout_ticks;
            if (acc) begin
                r_len    <= n_len;
                r_recent <= n_recent;
                r_hdr_ok <= n_hdr_ok;
                r_vflag  <= n_vflag;
                r_idle   <= n_idle;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    r_ph[k]    <= n_ph[k];
                    r_field[k] <= n_field[k];
                end
            end
            if (!r_out_v || take) begin
                if (r_sk_v) begin
                    r_sk_v  <= 1'b0;
                    r_out_v <= 1'b1;
                end else begin
                    r_out_v <= acc;
                end
            end else if (acc) begin
                r_sk_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_whole <= n_whole;
            r_frac  <= n_frac;
            r_fd    <= n_fd;
            for (int k = 0; k < NUM_KEYS; k++) r_neg[k] <= n_neg[k];
            for (int k = 1; k < NUM_KEYS; k++) r_mag[k] <= n_mag[k];
        end
        if (!r_out_v || take) begin
            if (r_sk_v) r_out <= r_sk;
            else if (acc) r_out <= new_res;
        end else if (acc) begin
            r_sk <= new_res;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.data_valid    = r_out.data_valid;
    assign o_out.perclos       = r_out.perclos;
    assign o_out.yawn_cnt      = r_out.yawn_cnt;
    assign o_out.phone_val     = r_out.phone_val;
    assign o_out.hat_on        = r_out.hat_on;
    assign o_out.fatigue_level = r_out.fatigue_level;
    assign o_out.line_accepted = r_out.line_accepted;

endmodule

/* sv/tlfp_checker.sv */
// Checker: port-level assertions for the telemetry line field parser, and its bind.
module tlfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_data_valid,
    input logic        i_out_line_accepted,
    input logic [15:0] i_out_perclos
);
    a_acc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_line_accepted |-> i_out_data_valid)
        else $error("accepted line without valid data");

    a_ready_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty result register");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_perclos))
        else $error("stalled result changed");
endmodule

bind telemetry_line_field_parser_unit tlfp_checker u_tlfp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_data_valid    (o_out.data_valid),
    .i_out_line_accepted (o_out.line_accepted),
    .i_out_perclos       (o_out.perclos)
);

/* tb/tb_top.sv */
// Testbench for the telemetry line field parser: directed and random lines and ticks, checked per field.
`timescale 1ns / 1ps
module tb_top;
    import tlfp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tlfp_in_if  in_ch();
    tlfp_out_if out_ch();
    tlfp_cfg_if cfg_ch();

    telemetry_line_field_parser_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_request;

    t_request    pending_q[$];
    t_result     expected_q[$];
    logic [15:0] cfg_q[$];

    // predictor state
    logic [7:0]  line_buf[LINE_CAP];
    int          line_len;
    logic [15:0] fields[NUM_KEYS];
    logic        valid_now;
    int          idle_cnt;
    int          timeout_val;

    int  errors = 0;
    int  cycles = 0;
    int  hold_off = 0;
    int  half_q = 0;
    logic calm = 1'b0;
    logic sender_pause = 1'b0;

    function automatic logic digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int skip_blanks_sign(int pos, output logic neg);
        while (pos < line_len && (line_buf[pos] == " " || line_buf[pos] == 8'h09 ||
               line_buf[pos] == 8'h0B || line_buf[pos] == 8'h0C)) pos++;
        neg = 1'b0;
        if (pos < line_len && (line_buf[pos] == "-" || line_buf[pos] == "+")) begin
            neg = line_buf[pos] == "-";
            pos++;
        end
        return pos;
    endfunction

    function automatic logic [15:0] decode_int(int pos);
        logic neg;
        int   mag;
        mag = 0;
        pos = skip_blanks_sign(pos, neg);
        while (pos < line_len && digit_char(line_buf[pos])) begin
            mag = mag * 10 + (line_buf[pos] - "0");
            if (mag > 40000) mag = 40000;
            pos++;
        end
        if (neg) begin
            if (mag > 32768) mag = 32768;
            return 16'(-mag);
        end
        if (mag > 32767) mag = 32767;
        return 16'(mag);
    endfunction

    function automatic logic [15:0] decode_ratio(int pos);
        logic neg;
        int   whole, frac, nd, total;
        whole = 0; frac = 0; nd = 0;
        pos = skip_blanks_sign(pos, neg);
        while (pos < line_len && digit_char(line_buf[pos])) begin
            whole = whole * 10 + (line_buf[pos] - "0");
            if (whole > 10) whole = 10;
            pos++;
        end
        if (pos < line_len && line_buf[pos] == ".") begin
            pos++;
            while (pos < line_len && digit_char(line_buf[pos])) begin
                if (nd < 4) begin
                    frac = frac * 10 + (line_buf[pos] - "0");
                    nd++;
                end
                pos++;
            end
        end
        while (nd < 4) begin
            frac *= 10;
            nd++;
        end
        if (neg) return 16'd0;
        total = whole * 10000 + frac;
        if (total > 65535) total = 65535;
        return 16'(total);
    endfunction

    function automatic int find_field(logic [63:0] txt, int n);
        int i, j;
        logic hit;
        if (line_len < n) return -1;
        for (i = 0; i + n <= line_len; i++) begin
            hit = 1'b1;
            for (j = 0; j < n; j++)
                if (line_buf[i + j] != txt[8 * (n - 1 - j) +: 8]) hit = 1'b0;
            if (hit) return i + n;
        end
        return -1;
    endfunction

    function automatic logic close_line();
        int at;
        if (line_len <= 5 || line_buf[0] != "D" || line_buf[1] != "M" || line_buf[2] != "S" ||
            line_buf[3] != ",") return 1'b0;
        at = find_field(KEY_PERCLOS, 8);
        if (at >= 0) fields[0] = decode_ratio(at);
        at = find_field(64'(KEY_YAWN), 5);
        if (at >= 0) fields[1] = decode_int(at);
        at = find_field(64'(KEY_PHONE), 6);
        if (at >= 0) fields[2] = decode_int(at);
        at = find_field(64'(KEY_HAT), 4);
        if (at >= 0) fields[3] = decode_int(at);
        at = find_field(64'(KEY_LVL), 4);
        if (at >= 0) fields[4] = decode_int(at);
        valid_now = 1'b1;
        idle_cnt = 0;
        return 1'b1;
    endfunction

    function automatic void parse_request(t_request r);
        t_result res;
        logic acc;
        acc = 1'b0;
        if (!r.kind) begin
            if (r.rx_byte == CH_LF || r.rx_byte == CH_CR) begin
                acc = close_line();
                line_len = 0;
            end else if (line_len < LINE_CAP - 1) begin
                line_buf[line_len] = r.rx_byte;
                line_len++;
            end
        end else if (valid_now) begin
            if (idle_cnt >= timeout_val) valid_now = 1'b0;
            else idle_cnt++;
        end
        res.data_valid    = valid_now;
        res.perclos       = fields[0];
        res.yawn_cnt      = fields[1];
        res.phone_val     = fields[2];
        res.hat_on        = fields[3];
        res.fatigue_level = fields[4];
        res.line_accepted = acc;
        expected_q.push_back(res);
    endfunction

    task automatic push_byte(logic [7:0] b);
        t_request r;
        r.kind = 1'b0;
        r.rx_byte = b;
        pending_q.push_back(r);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_tick();
        t_request r;
        r.kind = 1'b1;
        r.rx_byte = 8'($urandom);
        pending_q.push_back(r);
    endtask

    function automatic string rand_number(logic ratio);
        string s, d;
        int n;
        s = "";
        case ($urandom_range(0, 5))
            0: s = " ";
            1: s = "\t";
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: s = {s, "-"};
            1: s = {s, "+"};
            default: ;
        endcase
        n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            d.itoa($urandom_range(0, 9));
            s = {s, d};
        end
        if (ratio && $urandom_range(0, 1)) begin
            s = {s, "."};
            n = $urandom_range(0, 7);
            for (int i = 0; i < n; i++) begin
                d.itoa($urandom_range(0, 9));
                s = {s, d};
            end
        end
        return s;
    endfunction

    task automatic push_random_line();
        string s;
        string keys[5];
        logic tail;
        keys = '{"PERCLOS:", "YAWN:", "PHONE:", "HAT:", "LVL:"};
        s = $urandom_range(0, 9) == 0 ? "DMX," : "DMS,";
        for (int k = 0; k < 5; k++) begin
            if ($urandom_range(0, 4) != 0) s = {s, keys[k], rand_number(k == 0), ","};
            if ($urandom_range(0, 9) == 0) s = {s, keys[$urandom_range(0, 4)], "7,"};
        end
        tail = $urandom_range(0, 15) == 0;
        if (tail) s = {s, "garbage"};
        push_text(s);
        if (tail) begin
            push_byte(8'h00);
            push_byte("x");
        end
        push_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
        if ($urandom_range(0, 3) == 0) push_tick();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.kind <= 1'b0;
            in_ch.rx_byte <= 8'd0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) parse_request({in_ch.kind, in_ch.rx_byte});
            if (pending_q.size() > 0 && !sender_pause && (calm || $urandom_range(0, 99) >= 35))
            begin
                t_request r;
                r = pending_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.kind <= r.kind;
                in_ch.rx_byte <= r.rx_byte;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result", $time);
                    errors++;
                end else begin
                    t_result e, a;
                    e = expected_q.pop_front();
                    a = {out_ch.data_valid, out_ch.perclos, out_ch.yawn_cnt,
                         out_ch.phone_val, out_ch.hat_on, out_ch.fatigue_level,
                         out_ch.line_accepted};
                    if (e.data_valid != a.data_valid || e.perclos != a.perclos ||
                        e.yawn_cnt != a.yawn_cnt || e.phone_val != a.phone_val ||
                        e.hat_on != a.hat_on || e.fatigue_level != a.fatigue_level ||
                        e.line_accepted != a.line_accepted) begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, a);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || $urandom_range(0, 99) >= 35;
            end
        end
    end

    // configuration writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.timeout_ticks <= 16'd0;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            timeout_val = cfg_ch.timeout_ticks;
            cfg_ch.valid <= 1'b0;
        end else if (!cfg_ch.valid && cfg_q.size() > 0) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.timeout_ticks <= cfg_q.pop_front();
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        cfg_q.push_back(v);
        @(posedge i_clk);
        while (cfg_q.size() > 0 || cfg_ch.valid) @(posedge i_clk);
    endtask

    logic [15:0] timeouts[4] = '{16'd0, 16'd3, 16'd65535, 16'd12};

    initial begin
        line_len = 0;
        valid_now = 1'b0;
        idle_cnt = 0;
        timeout_val = TIMEOUT_RESET;
        for (int k = 0; k < NUM_KEYS; k++) fields[k] = 16'd0;
        for (int i = 0; i < LINE_CAP; i++) line_buf[i] = 8'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        push_text("DMS,PERCLOS:0.12345,YAWN:-99999,PHONE:40000,HAT: +7,LVL:x\n");
        push_text("DMS,PERCLOS:-0.5,YAWN:32768,PHONE:-32768\r");
        push_text("DMS,PERCLOS:7.5\n");
        push_text("DMS,\n");
        push_text("\n");
        for (int i = 0; i < 140; i++) push_byte(i < 4 ? HDR_TEXT[8 * (3 - i) +: 8] : 8'hFF);
        push_byte(CH_LF);
        push_byte(8'h00); push_byte(8'h80); push_byte(CH_LF);
        push_text("DMS,YAWN:12");
        push_byte(8'h00);
        push_text("3,HAT:5\n");
        for (int i = 0; i < 45; i++) push_tick();
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_timeout(timeouts[ph]);
            calm = ph == 1;
            if (ph == 2) hold_off = 300;
            for (int i = 0; i < 3; i++) push_random_line();
            for (int i = 0; i < 20 && pending_q.size() < 260; i++) begin
                if ($urandom_range(0, 3) == 0) push_tick();
                else push_byte(8'($urandom));
            end
            for (int i = 0; i < timeouts[ph] + 2 && i < 20; i++) push_tick();
            if (ph == 0) begin
                half_q = pending_q.size() / 2;
                while (pending_q.size() > half_q) @(posedge i_clk);
                sender_pause = 1'b1;
                while (in_ch.valid || expected_q.size() > 0) @(posedge i_clk);
                sender_pause = 1'b0;
            end
            wait_drained();
        end
        calm = 1'b0;
        wait_drained();
        repeat (6) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = 1'b0;
        in_ch.rx_byte = 8'd0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.timeout_ticks = 16'd0;
    end
endmodule
